// ----- hdl/present80_block_encrypt_core_macros.svh -----
// Assertion macros for the PRESENT-80 encrypt core.
// Included by present80_block_encrypt_core, the module that carries concurrent assertions; no dependencies.
`ifndef PRESENT80_BLOCK_ENCRYPT_CORE_MACROS_SVH
`define PRESENT80_BLOCK_ENCRYPT_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define PRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle, always checked
`define PRS_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/prs80_pkg.sv -----
// Package for the PRESENT-80 encrypt core: widths, register indexes, the
// S-box and permutation layers, and the beat struct passed between round cells.
package prs80_pkg;

  localparam int BLK_W      = 64;
  localparam int KEY_W      = 80;
  localparam int KEY_LO_W   = 16;
  localparam int RC_W       = 5;
  localparam int ROUNDS_DEF = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_UPPER = 1'b0,
    REG_KEY_LOWER = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             valid;
    logic [BLK_W-1:0] state;
    logic [KEY_W-1:0] key;
  } prs_beat_t;

  function automatic logic [3:0] sbox4(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      default: y = 4'h2;
    endcase
    return y;
  endfunction

  function automatic logic [BLK_W-1:0] sub_layer(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] r;
    for (int n = 0; n < BLK_W / 4; n++) begin
      r[4*n +: 4] = sbox4(s[4*n +: 4]);
    end
    return r;
  endfunction

  // bit i moves to 16*(i mod 4) + i/4; bit 63 lands on itself
  function automatic logic [BLK_W-1:0] perm_layer(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] r;
    for (int i = 0; i < BLK_W; i++) begin
      r[16 * (i % 4) + i / 4] = s[i];
    end
    return r;
  endfunction

endpackage

// ----- hdl/prs80_round_cell.sv -----
// One PRESENT round as a pipeline cell: round key add, S-box, permutation,
// and the key schedule step. Depends on prs80_pkg.
module prs80_round_cell import prs80_pkg::*; #(
  parameter logic [RC_W-1:0] RC = RC_W'(1)
) (
  input  logic      clk,
  input  logic      rst_n,
  input  prs_beat_t beat_in,
  output prs_beat_t beat_out
);

  logic             valid_r, valid_nxt;
  logic [BLK_W-1:0] state_r, state_nxt;
  logic [KEY_W-1:0] key_r,   key_nxt;
  logic [KEY_W-1:0] key_rot;

  always_comb begin
    valid_nxt = beat_in.valid;
    state_nxt = perm_layer(sub_layer(beat_in.state ^ beat_in.key[KEY_W-1 -: BLK_W]));
    key_rot   = {beat_in.key[18:0], beat_in.key[KEY_W-1:19]};
    key_nxt   = key_rot;
    key_nxt[KEY_W-1 -: 4] = sbox4(key_rot[KEY_W-1 -: 4]);
    key_nxt[19:15]        = key_rot[19:15] ^ RC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    key_r   <= key_nxt;
  end

  assign beat_out.valid = valid_r;
  assign beat_out.state = state_r;
  assign beat_out.key   = key_r;

endmodule

// ----- hdl/present80_block_encrypt_core.sv -----
// PRESENT-80 block encryption, fully unrolled into a chain of round cells.
// One block is accepted every clock; its ciphertext passes through the ROUNDS
// round cells and then the final key-add output register. busy stays low: the
// chain never stops. The result shows for one cycle on out_valid and the
// receiver cannot stall it, so it must take every beat. Each beat carries its
// own key copy through the chain; change the key only when no block is in
// flight. Depends on prs80_pkg and prs80_round_cell.
`include "present80_block_encrypt_core_macros.svh"

module present80_block_encrypt_core import prs80_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [BLK_W-1:0]      in_plaintext,
  output logic                  out_valid,
  output logic [BLK_W-1:0]      out_ciphertext,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [BLK_W-1:0]    key_upper_r;
  logic [KEY_LO_W-1:0] key_lower_r;
  logic                out_valid_r;
  logic [BLK_W-1:0]    out_ct_r;
  prs_beat_t           chain [0:ROUNDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_upper_r <= '0;
      key_lower_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_UPPER: key_upper_r <= cfg_data;
        REG_KEY_LOWER: key_lower_r <= cfg_data[KEY_LO_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy           = 1'b0;
  assign chain[0].valid = start;
  assign chain[0].state = in_plaintext;
  assign chain[0].key   = {key_upper_r, key_lower_r};

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    prs80_round_cell #(
      .RC(RC_W'(g + 1))
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .beat_in (chain[g]),
      .beat_out(chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[ROUNDS].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_ct_r <= chain[ROUNDS].state ^ chain[ROUNDS].key[KEY_W-1 -: BLK_W];
  end

  assign out_valid      = out_valid_r;
  assign out_ciphertext = out_ct_r;

  `PRS_ASSERT_IMP(a_latency, clk, rst_n, start, ##(ROUNDS + 1) out_valid, "beat lost in chain")
  `PRS_ASSERT_IMP(a_no_phantom, clk, rst_n, out_valid, $past(start, ROUNDS + 1), "phantom beat")
  `PRS_ASSERT_NEXT(a_reset_quiet, clk, !rst_n, !out_valid, "result strobe after reset")

endmodule
